[rtl/dtls_pkg.sv]
// Shared types and character codes for the decimal token line summer.
`default_nettype none

package dtls_pkg;

  localparam int unsigned SumW   = 64;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned StatW  = 2;

  // Line status codes reported with each result item
  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NONE    = 2'd2,
    ST_EMPTY   = 2'd3
  } line_status_t;

  // Parse phase of the current line
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SKIP   = 3'd1,
    PH_SIGN   = 3'd2,
    PH_DIGITS = 3'd3,
    PH_DONE   = 3'd4
  } parse_phase_t;

  // Character codes
  localparam logic [ByteW-1:0] CH_NUL   = 8'h00;
  localparam logic [ByteW-1:0] CH_TAB   = 8'h09;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [ByteW-1:0] CH_COMMA = 8'h2C;
  localparam logic [ByteW-1:0] CH_MINUS = 8'h2D;
  localparam logic [ByteW-1:0] CH_DOT   = 8'h2E;
  localparam logic [ByteW-1:0] CH_ZERO  = 8'h30;
  localparam logic [ByteW-1:0] CH_NINE  = 8'h39;

endpackage : dtls_pkg

`default_nettype wire

[rtl/decimal_token_line_summer.sv]
// Top level: byte-serial decimal token parser that sums the signed tokens of a line.
`default_nettype none

// Accepts one text byte per cycle, every cycle, for as long as the result side
// keeps up. Each byte updates the parse state in a single pass: a token digit
// costs one multiply-by-ten (two shifts and an add) and a token end costs one
// 64-bit add into the running sum. The NUL byte closes the line and loads the
// output register, so its result item appears in the cycle after the NUL is
// taken; a held result stalls the input only when a new byte arrives while
// the output register is still full and not being taken. Signed token values
// are accumulated directly (a negative token counts down), so all sums wrap
// modulo 2^64. line_sum is zero unless line_status reports ok.
module decimal_token_line_summer
  import dtls_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input channel
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [ByteW-1:0]  in_tdata,   // [7:0] text_byte
  // Result channel
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [SumW-1:0]        out_tdata,  // [63:0] line_sum
  output logic [StatW-1:0]       out_tuser   // [1:0] line_status
);

  // State registers
  parse_phase_t         phase_r,   phase_nxt;
  logic                 neg_r,     neg_nxt;
  logic [SumW-1:0]      tok_r,     tok_nxt;
  logic [SumW-1:0]      sum_r,     sum_nxt;
  logic                 found_r,   found_nxt;
  line_status_t         pend_r,    pend_nxt;

  // Result register
  logic                 out_valid_r;
  line_status_t         out_status_r, out_status_nxt;
  logic [SumW-1:0]      out_sum_r,    out_sum_nxt;

  logic                 in_acc;
  logic                 out_acc;
  logic [ByteW-1:0]     b;
  logic                 is_digit, is_blank, is_sign, is_sep;
  logic [3:0]           dig;
  logic [SumW-1:0]      dig_ext, dig_signed, tok_mac, sum_commit;
  logic                 end_found;
  logic [SumW-1:0]      end_sum;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_valid_r && out_tready;

  // Classify the incoming byte
  assign b        = in_tdata;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR);
  assign is_sign  = (b == CH_PLUS) || (b == CH_MINUS);
  assign is_sep   = (b == CH_DOT) || (b == CH_COMMA);
  assign dig      = 4'(b - CH_ZERO);
  assign dig_ext  = {{(SumW-4){1'b0}}, dig};

  // Signed digit and token accumulate: tok*10 +/- digit
  assign dig_signed = neg_r ? (SumW'(0) - dig_ext) : dig_ext;
  assign tok_mac    = (tok_r << 3) + (tok_r << 1) + dig_signed;
  assign sum_commit = sum_r + tok_r;

  // Closing values when the line ends
  assign end_found = found_r || (phase_r == PH_DIGITS);
  assign end_sum   = (phase_r == PH_DIGITS) ? sum_commit : sum_r;

  // Next parse state for one accepted byte
  always_comb begin
    phase_nxt      = phase_r;
    neg_nxt        = neg_r;
    tok_nxt        = tok_r;
    sum_nxt        = sum_r;
    found_nxt      = found_r;
    pend_nxt       = pend_r;
    out_status_nxt = out_status_r;
    out_sum_nxt    = out_sum_r;

    if (b == CH_NUL) begin
      // Close the line and return to line start
      if (phase_r == PH_START) begin
        out_status_nxt = ST_EMPTY;
        out_sum_nxt    = '0;
      end else if (pend_r != ST_OK) begin
        out_status_nxt = pend_r;
        out_sum_nxt    = '0;
      end else if (end_found) begin
        out_status_nxt = ST_OK;
        out_sum_nxt    = end_sum;
      end else begin
        out_status_nxt = ST_NONE;
        out_sum_nxt    = '0;
      end
      phase_nxt = PH_START;
      neg_nxt   = 1'b0;
      tok_nxt   = '0;
      sum_nxt   = '0;
      found_nxt = 1'b0;
      pend_nxt  = ST_OK;
    end else begin
      case (phase_r)
        PH_START, PH_SKIP, PH_DIGITS: begin
          if (phase_r == PH_START && b == CH_LF) begin
            pend_nxt  = ST_EMPTY;
            phase_nxt = PH_DONE;
          end else if (phase_r == PH_DIGITS && is_digit) begin
            tok_nxt = tok_mac;
          end else if (phase_r == PH_DIGITS && is_sep) begin
            pend_nxt  = ST_INVALID;
            phase_nxt = PH_DONE;
          end else begin
            // Commit a finished token, then treat the byte as between tokens
            if (phase_r == PH_DIGITS) begin
              sum_nxt   = sum_commit;
              found_nxt = 1'b1;
              tok_nxt   = '0;
              neg_nxt   = 1'b0;
            end
            if (is_blank) begin
              phase_nxt = PH_SKIP;
            end else if (is_sign) begin
              neg_nxt   = (b == CH_MINUS);
              tok_nxt   = '0;
              phase_nxt = PH_SIGN;
            end else if (is_digit) begin
              neg_nxt   = 1'b0;
              tok_nxt   = dig_ext;
              phase_nxt = PH_DIGITS;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
        end
        PH_SIGN: begin
          if (is_digit) begin
            tok_nxt   = dig_signed;
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      neg_r       <= 1'b0;
      tok_r       <= '0;
      sum_r       <= '0;
      found_r     <= 1'b0;
      pend_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        tok_r   <= tok_nxt;
        sum_r   <= sum_nxt;
        found_r <= found_nxt;
        pend_r  <= pend_nxt;
      end
      if (in_acc && b == CH_NUL) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded on the line end
  always_ff @(posedge clk) begin
    if (in_acc && b == CH_NUL) begin
      out_status_r <= out_status_nxt;
      out_sum_r    <= out_sum_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_status_r;

  // Line end always returns the parser to a clean line start
  a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && b == CH_NUL) |=> (phase_r == PH_START && sum_r == '0 && !found_r))
    else $error("parser state not cleared after line end");

  // A failed line reports a zero sum
  a_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_sum_r == '0))
    else $error("non-zero sum with failing status");

  // A decided failure status only stands once parsing is over
  a_pend_done: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != ST_OK) |-> (phase_r == PH_DONE))
    else $error("pending status set while still parsing");

  // No partial token lingers between tokens
  a_tok_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_START || phase_r == PH_SKIP) |-> (tok_r == '0 && !neg_r))
    else $error("stale token value between tokens");

  // Nothing is counted before the line has started
  a_found_start: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_START) |-> (!found_r && sum_r == '0))
    else $error("token counted at line start");

endmodule : decimal_token_line_summer

`default_nettype wire

[tb/tb_decimal_token_line_summer.sv]
// Self-checking testbench for the decimal token line summer: directed lines, then random text.
`timescale 1ns / 100ps

module tb_decimal_token_line_summer;
  import dtls_pkg::*;

  localparam int unsigned RandomBytes = 1850;
  localparam int unsigned IdlePct     = 31;

  // One result item: line status and wrapped sum
  typedef struct packed {
    line_status_t      status;
    logic [SumW-1:0]   sum;
  } line_result_t;

  // Directed line: text right-aligned, leading zero bytes skipped, NUL appended
  typedef struct packed {
    logic [63:0]       text;
    bit                typed;
    line_status_t      status;
    logic [SumW-1:0]   sum;
  } line_case_t;

  localparam line_case_t DirectedLines [11] = '{
    '{"",      1'b1, ST_EMPTY,   64'd0},
    '{"\n5",   1'b1, ST_EMPTY,   64'd0},
    '{"+0 9",  1'b1, ST_OK,      64'd9},
    '{"12-3",  1'b0, ST_OK,      64'd0},
    '{"-9,",   1'b1, ST_INVALID, 64'd0},
    '{"7.",    1'b1, ST_INVALID, 64'd0},
    '{"+ ",    1'b1, ST_NONE,    64'd0},
    '{" \t\r", 1'b1, ST_NONE,    64'd0},
    '{"4\n8",  1'b1, ST_OK,      64'd4},
    '{"1\3772", 1'b1, ST_OK,     64'd1},
    '{"-1",    1'b1, ST_OK,      64'hFFFF_FFFF_FFFF_FFFF}
  };

  localparam logic [ByteW-1:0] Blanks [3] = '{CH_SPACE, CH_TAB, CH_CR};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [ByteW-1:0]    in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SumW-1:0]     out_tdata;   // [63:0] line_sum
  logic [StatW-1:0]    out_tuser;   // [1:0] line_status

  // Shadow parse state of the line being fed in
  parse_phase_t        cur_phase;
  bit                  tok_neg;
  logic [SumW-1:0]     tok_val;
  logic [SumW-1:0]     line_acc;
  bit                  seen_token;
  line_status_t        held_status;

  line_result_t        line_results_q [$];
  line_result_t        want_res;
  int unsigned         sent_bytes;
  int unsigned         mismatches;
  bit                  steady;

  decimal_token_line_summer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit is_digit(logic [ByteW-1:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // Return the shadow state to line start
  function automatic void clear_line();
    cur_phase   = PH_START;
    tok_neg     = 1'b0;
    tok_val     = '0;
    line_acc    = '0;
    seen_token  = 1'b0;
    held_status = ST_OK;
  endfunction

  // Add the finished token into the line sum
  function automatic void close_token();
    line_acc   = line_acc + (tok_neg ? -tok_val : tok_val);
    seen_token = 1'b1;
    tok_val    = '0;
    tok_neg    = 1'b0;
  endfunction

  // Handle a byte that arrives between tokens
  function automatic void start_or_skip(logic [ByteW-1:0] b);
    if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
      cur_phase = PH_SKIP;
    end else if (b == CH_PLUS || b == CH_MINUS) begin
      tok_neg   = (b == CH_MINUS);
      tok_val   = '0;
      cur_phase = PH_SIGN;
    end else if (is_digit(b)) begin
      tok_neg   = 1'b0;
      tok_val   = SumW'(b - CH_ZERO);
      cur_phase = PH_DIGITS;
    end else begin
      cur_phase = PH_DONE;
    end
  endfunction

  // Advance the shadow state by one byte; return 1 with the result on NUL
  function automatic bit predict_byte(input logic [ByteW-1:0] b, output line_result_t res);
    res = '{ST_OK, '0};
    if (b == CH_NUL) begin
      if (cur_phase == PH_START) begin
        res.status = ST_EMPTY;
      end else begin
        if (cur_phase == PH_DIGITS) close_token();
        if (held_status != ST_OK) res.status = held_status;
        else if (seen_token) res.sum = line_acc;
        else res.status = ST_NONE;
      end
      clear_line();
      return 1'b1;
    end
    case (cur_phase)
      PH_START: begin
        if (b == CH_LF) begin
          held_status = ST_EMPTY;
          cur_phase   = PH_DONE;
        end else begin
          start_or_skip(b);
        end
      end
      PH_SKIP: begin
        start_or_skip(b);
      end
      PH_SIGN: begin
        if (is_digit(b)) begin
          tok_val   = SumW'(b - CH_ZERO);
          cur_phase = PH_DIGITS;
        end else begin
          cur_phase = PH_DONE;
        end
      end
      PH_DIGITS: begin
        if (is_digit(b)) begin
          tok_val = tok_val * 64'd10 + SumW'(b - CH_ZERO);
        end else if (b == CH_DOT || b == CH_COMMA) begin
          held_status = ST_INVALID;
          cur_phase   = PH_DONE;
        end else begin
          close_token();
          start_or_skip(b);
        end
      end
      default: begin
        cur_phase = PH_DONE;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Offer one byte from a falling edge, hold until taken, then predict
  task automatic send_byte(input logic [ByteW-1:0] b, input bit typed,
                           input line_result_t typed_res);
    line_result_t res;
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    if (predict_byte(b, res)) line_results_q.push_back(typed ? typed_res : res);
    sent_bytes++;
    @(negedge clk);
  endtask

  // Result side: stall at random, never in the steady stretch
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= IdlePct);
  end

  // Compare each result item taken with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (line_results_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, line_status %0d sum %0h",
                                  out_tuser, out_tdata));
      end else begin
        want_res = line_results_q.pop_front();
        if (out_tuser !== want_res.status)
          report_mismatch($sformatf("line_status %0d, want %0d", out_tuser,
                                    want_res.status));
        if (out_tdata !== want_res.sum)
          report_mismatch($sformatf("line_sum %0h, want %0h", out_tdata, want_res.sum));
      end
    end
  end

  initial begin : stimulus
    logic [ByteW-1:0] text_q [$];
    logic [ByteW-1:0] c;
    int unsigned      pick;
    int unsigned      ntok;
    int unsigned      nsep;
    int unsigned      ndig;

    clear_line();
    mismatches = 0;
    sent_bytes = 0;
    steady     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed lines
    foreach (DirectedLines[i]) begin
      for (int k = 7; k >= 0; k--) begin
        c = DirectedLines[i].text[8*k +: 8];
        if (c != CH_NUL)
          send_byte(c, DirectedLines[i].typed, '{DirectedLines[i].status, DirectedLines[i].sum});
      end
      send_byte(CH_NUL, DirectedLines[i].typed, '{DirectedLines[i].status, DirectedLines[i].sum});
    end

    // Random lines: mostly well-formed token lists, some empty lines and noise
    sent_bytes = 0;
    while (sent_bytes < RandomBytes) begin
      steady = (sent_bytes >= 700 && sent_bytes < 1000);
      text_q.delete();
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        ntok = $urandom_range(1, 5);
        for (int t = 0; t < ntok; t++) begin
          nsep = $urandom_range(0, 2);
          if (t > 0 && nsep == 0 && $urandom_range(0, 3) != 0) nsep = 1;
          repeat (nsep) text_q.push_back(Blanks[$urandom_range(0, 2)]);
          case ($urandom_range(0, 2))
            1: text_q.push_back(CH_PLUS);
            2: text_q.push_back(CH_MINUS);
            default: ;
          endcase
          // Long runs of digits exercise the wrap of token and sum
          ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 6);
          repeat (ndig) text_q.push_back(ByteW'(CH_ZERO + $urandom_range(0, 9)));
        end
        // Break or pad the tail now and then
        case ($urandom_range(0, 11))
          0: text_q.push_back(CH_DOT);
          1: text_q.push_back(CH_COMMA);
          2: text_q.push_back(CH_LF);
          3: repeat ($urandom_range(1, 3)) text_q.push_back(ByteW'($urandom_range(1, 255)));
          4: text_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
          5: text_q.push_back(Blanks[$urandom_range(0, 2)]);
          default: ;
        endcase
      end else if (pick < 82) begin
        if ($urandom_range(0, 1)) begin
          text_q.push_back(CH_LF);
          repeat ($urandom_range(0, 4)) text_q.push_back(ByteW'($urandom_range(1, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 8)) text_q.push_back(ByteW'($urandom_range(1, 255)));
      end
      foreach (text_q[j]) send_byte(text_q[j], 1'b0, '0);
      send_byte(CH_NUL, 1'b0, '0);
    end
    steady = 1'b0;

    // Stop offering bytes once the last one is taken
    in_tvalid <= 1'b0;

    // Drain, then allow for the output register
    while (line_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[decimal_token_line_summer.f]
rtl/dtls_pkg.sv
rtl/decimal_token_line_summer.sv
tb/tb_decimal_token_line_summer.sv
